### sv/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### sv/nvg_pkg.sv
// Types, constants and saturation helpers of the N-body Verlet block.
package nvg_pkg;

   localparam logic [47:0] MAX_MAG = 48'hFFFF_FFFF_FFFF;
   localparam logic [47:0] MAX_POS = 48'h7FFF_FFFF_FFFF;
   localparam logic [47:0] MIN_NEG = 48'h8000_0000_0000;
   localparam logic signed [49:0] POS_LIM = 50'sh0_7FFF_FFFF_FFFF;
   localparam logic signed [49:0] NEG_LIM = 50'sh3_8000_0000_0000;
   localparam logic [31:0] TIME_STEP_RESET = 32'd42949673;
   localparam logic [47:0] GRAVITY_RESET = 48'h0001_0000_0000;
   localparam int unsigned PH_W = 4;

   typedef enum logic {
      CMD_LOAD = 1'b0,
      CMD_TICK = 1'b1
   } cmd_type;

   typedef enum logic {
      CSR_TIME_STEP = 1'b0,
      CSR_GRAVITY   = 1'b1
   } csr_type;

   typedef enum logic [1:0] {
      ALU_MUL  = 2'd0,
      ALU_MAC  = 2'd1,
      ALU_DIV  = 2'd2,
      ALU_SQRT = 2'd3
   } alu_op_type;

   typedef struct packed {
      logic        start;
      alu_op_type  op;
      logic [63:0] a;
      logic [63:0] b;
      logic [97:0] num;
      logic [48:0] den;
   } alu_req_type;

   typedef struct packed {
      logic        ov;
      logic [47:0] v;
   } sat_type;

   function automatic logic signed [49:0] sext50(input logic [47:0] x);
      sext50 = {{2{x[47]}}, x};
   endfunction

   function automatic logic [63:0] mag64(input logic signed [49:0] x);
      logic [49:0] n;
      n = x[49] ? (~x + 50'd1) : x;
      mag64 = {14'b0, n};
   endfunction

   // Signed product finish: take bits 95:32 of |a|*b, cap, apply sign.
   function automatic sat_type smul_fin(input logic [127:0] p, input logic neg);
      logic [63:0] mag;
      sat_type     r;
      if (p[127:96] != '0) mag = {16'b0, MAX_MAG};
      else mag = p[95:32];
      if (mag > {16'b0, MIN_NEG}) mag = {16'b0, MIN_NEG};
      if (neg) begin
         r.ov = 1'b0;
         r.v  = 48'(~mag + 64'd1);
      end else if (mag > {16'b0, MAX_POS}) begin
         r.ov = 1'b1;
         r.v  = MAX_POS;
      end else begin
         r.ov = 1'b0;
         r.v  = mag[47:0];
      end
      return r;
   endfunction

   // Unsigned product finish, capped at 2^48-1.
   function automatic sat_type umul_fin(input logic [127:0] p);
      sat_type r;
      if (p[127:80] != '0) begin
         r.ov = 1'b1;
         r.v  = MAX_MAG;
      end else begin
         r.ov = 1'b0;
         r.v  = p[79:32];
      end
      return r;
   endfunction

   // Quotient cap.
   function automatic sat_type div_cap(input logic [95:0] q, input logic [47:0] cap);
      sat_type r;
      if (q > {48'b0, cap}) begin
         r.ov = 1'b1;
         r.v  = cap;
      end else begin
         r.ov = 1'b0;
         r.v  = q[47:0];
      end
      return r;
   endfunction

   // Clamp a grown sum back to signed 48 bits.
   function automatic sat_type clamp50(input logic signed [49:0] s);
      sat_type r;
      if (s > POS_LIM) begin
         r.ov = 1'b1;
         r.v  = MAX_POS;
      end else if (s < NEG_LIM) begin
         r.ov = 1'b1;
         r.v  = MIN_NEG;
      end else begin
         r.ov = 1'b0;
         r.v  = s[47:0];
      end
      return r;
   endfunction

endpackage

### sv/nvg_alu.sv
// Shared arithmetic unit: 64x64 multiply-accumulate, 96-bit divide, square root.
module nvg_alu import nvg_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  alu_req_type   req,
   output logic          done,
   output logic [127:0]  res
);

   localparam logic [6:0] MUL_LAST  = 7'd3;
   localparam logic [6:0] DIV_LAST  = 7'd95;
   localparam logic [6:0] SQRT_LAST = 7'd48;

   logic         busy_ff, busy_in;
   logic         done_ff, done_in;
   alu_op_type   op_ff, op_in;
   logic [6:0]   cnt_ff, cnt_in;
   logic [63:0]  a_ff, a_in, b_ff, b_in;
   logic [127:0] acc_ff, acc_in;
   logic [97:0]  sh_ff, sh_in;
   logic [50:0]  rem_ff, rem_in;
   logic [48:0]  den_ff, den_in;
   logic [48:0]  root_ff, root_in;

   logic [31:0]  ah, bh;
   logic [63:0]  pp;
   logic [127:0] ppw;
   logic [49:0]  dt, dd;
   logic         dge;
   logic [52:0]  st, strial, sd;
   logic         sge;
   logic [6:0]   last_cnt;

   // Datapath of one step for each operation
   always_comb begin
      ah = cnt_ff[1] ? a_ff[63:32] : a_ff[31:0];
      bh = cnt_ff[0] ? b_ff[63:32] : b_ff[31:0];
      pp = ah * bh;
      priority if (cnt_ff[1] & cnt_ff[0]) ppw = {pp, 64'b0};
      else if (cnt_ff[1] | cnt_ff[0]) ppw = {32'b0, pp, 32'b0};
      else ppw = {64'b0, pp};

      dt  = {rem_ff[48:0], sh_ff[95]};
      dge = dt >= {1'b0, den_ff};
      dd  = dt - {1'b0, den_ff};

      st     = {rem_ff, sh_ff[97:96]};
      strial = {2'b0, root_ff, 2'b01};
      sge    = st >= strial;
      sd     = st - strial;

      unique case (op_ff)
         ALU_MUL, ALU_MAC: last_cnt = MUL_LAST;
         ALU_DIV:          last_cnt = DIV_LAST;
         ALU_SQRT:         last_cnt = SQRT_LAST;
      endcase
   end

   // Sequence the unit
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      op_in   = op_ff;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      sh_in   = sh_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      root_in = root_ff;
      if (!busy_ff) begin
         if (req.start) begin
            busy_in = 1'b1;
            op_in   = req.op;
            cnt_in  = '0;
            a_in    = req.a;
            b_in    = req.b;
            den_in  = req.den;
            rem_in  = '0;
            root_in = '0;
            if (req.op == ALU_MUL) acc_in = '0;
            if (req.op == ALU_DIV) sh_in = {2'b00, req.num[95:0]};
            else sh_in = req.num;
         end
      end else begin
         unique case (op_ff)
            ALU_MUL, ALU_MAC: acc_in = acc_ff + ppw;
            ALU_DIV: begin
               rem_in = dge ? {1'b0, dd} : {1'b0, dt};
               sh_in  = {2'b00, sh_ff[94:0], dge};
            end
            ALU_SQRT: begin
               rem_in  = sge ? sd[50:0] : st[50:0];
               root_in = {root_ff[47:0], sge};
               sh_in   = {sh_ff[95:0], 2'b00};
            end
         endcase
         cnt_in = cnt_ff + 7'd1;
         if (cnt_ff == last_cnt) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         op_ff   <= ALU_MUL;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         op_ff   <= op_in;
         cnt_ff  <= cnt_in;
      end
      a_ff    <= a_in;
      b_ff    <= b_in;
      acc_ff  <= acc_in;
      sh_ff   <= sh_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      root_ff <= root_in;
   end

   // Present the result of the last operation
   always_comb begin
      unique case (op_ff)
         ALU_MUL, ALU_MAC: res = acc_ff;
         ALU_DIV:          res = {32'b0, sh_ff[95:0]};
         ALU_SQRT:         res = {79'b0, root_ff};
      endcase
   end

   assign done = done_ff;

endmodule

### sv/nbody_verlet_gravity_step.sv
// Top level: body store and tick sequencer of the 2D N-body Verlet integrator.
//
//   port group  dir  role
//   req_*       in   command word: load one body or run one tick
//   rsp_*       out  body report word, one per slot after a tick, last marked
//   csr_*       in   register writes: time step, gravity constant
//
// A load with zero mass stores the body directly; any other mass also runs an inverse
// mass divide. Most of a tick for N slots and P alive pairs goes to the 96-step divider
// of the shared unit (four divides per pair).
// Reset clears all slots and returns the registers to their defaults.
// req_stall is high from acceptance of a tick until the last report word is taken,
// and during the inverse mass divide of a load; rsp_stall holds the current report word.
`include "assert_macros.svh"
module nbody_verlet_gravity_step import nvg_pkg::*; #(
   parameter int MAX_BODIES = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_command,
   input  logic [2:0]         req_body_index,
   input  logic               req_body_alive,
   input  logic [47:0]        req_body_mass,
   input  logic signed [47:0] req_start_pos_x,
   input  logic signed [47:0] req_start_pos_y,
   input  logic signed [47:0] req_start_vel_x,
   input  logic signed [47:0] req_start_vel_y,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [2:0]         rsp_out_index,
   output logic               rsp_out_alive,
   output logic signed [47:0] rsp_out_pos_x,
   output logic signed [47:0] rsp_out_pos_y,
   output logic signed [47:0] rsp_out_vel_x,
   output logic signed [47:0] rsp_out_vel_y,
   output logic signed [47:0] rsp_out_acc_x,
   output logic signed [47:0] rsp_out_acc_y,
   output logic               rsp_overflow,
   output logic               rsp_last,
   input  logic               csr_write_enable,
   input  logic               csr_index,
   input  logic [47:0]        csr_write_data
);

   localparam int IW = $clog2(MAX_BODIES);
   localparam logic [IW-1:0] LAST = IW'(MAX_BODIES - 1);

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_INV  = 7'b0000010,
      ST_DTSQ = 7'b0000100,
      ST_PRED = 7'b0001000,
      ST_PAIR = 7'b0010000,
      ST_FIN  = 7'b0100000,
      ST_OUT  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic [PH_W-1:0] ph_ff, ph_in;
   logic [IW-1:0] i_ff, i_in, j_ff, j_in, ld_ff, ld_in;
   logic issued_ff, issued_in;

   logic [31:0] time_step_ff;
   logic [47:0] gravity_ff;

   logic [47:0] px_ff [MAX_BODIES];
   logic [47:0] px_in [MAX_BODIES];
   logic [47:0] py_ff [MAX_BODIES];
   logic [47:0] py_in [MAX_BODIES];
   logic [47:0] vx_ff [MAX_BODIES];
   logic [47:0] vx_in [MAX_BODIES];
   logic [47:0] vy_ff [MAX_BODIES];
   logic [47:0] vy_in [MAX_BODIES];
   logic [47:0] ax_ff [MAX_BODIES];
   logic [47:0] ax_in [MAX_BODIES];
   logic [47:0] ay_ff [MAX_BODIES];
   logic [47:0] ay_in [MAX_BODIES];
   logic [47:0] mass_ff [MAX_BODIES];
   logic [47:0] mass_in [MAX_BODIES];
   logic [47:0] inv_ff [MAX_BODIES];
   logic [47:0] inv_in [MAX_BODIES];
   logic [47:0] fsx_ff [MAX_BODIES];
   logic [47:0] fsx_in [MAX_BODIES];
   logic [47:0] fsy_ff [MAX_BODIES];
   logic [47:0] fsy_in [MAX_BODIES];
   logic [47:0] npx_ff [MAX_BODIES];
   logic [47:0] npx_in [MAX_BODIES];
   logic [47:0] npy_ff [MAX_BODIES];
   logic [47:0] npy_in [MAX_BODIES];
   logic [MAX_BODIES-1:0] alive_ff, alive_in, ovf_ff, ovf_in;

   logic signed [49:0] sum_ff, sum_in;
   logic [47:0] dx_ff, dx_in, dy_ff, dy_in;
   logic [48:0] d_ff, d_in;
   logic [47:0] kv_ff, kv_in, fmx_ff, fmx_in, fmy_ff, fmy_in;
   logic [47:0] nax_ff, nax_in, nay_ff, nay_in;
   logic        pov_ff, pov_in;
   logic [31:0] dtsqh_ff, dtsqh_in;

   alu_req_type  alu_req;
   logic         alu_done;
   logic [127:0] alu_res;

   nvg_alu u_alu (
      .clock (clock),
      .reset (reset),
      .req   (alu_req),
      .done  (alu_done),
      .res   (alu_res)
   );

   // Sequencer and body store update
   always_comb begin
      logic            use_alu;
      logic            req_ok;
      logic [IW-1:0]   idx;
      sat_type         s, c, c2, u;
      logic signed [49:0] t50, fx, fy;
      logic            adv_pair;
      logic            ovi, ovj;

      state_in  = state_ff;
      ph_in     = ph_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      ld_in     = ld_ff;
      issued_in = issued_ff;
      px_in = px_ff;   py_in = py_ff;
      vx_in = vx_ff;   vy_in = vy_ff;
      ax_in = ax_ff;   ay_in = ay_ff;
      mass_in = mass_ff;
      inv_in  = inv_ff;
      fsx_in  = fsx_ff;
      fsy_in  = fsy_ff;
      npx_in  = npx_ff;
      npy_in  = npy_ff;
      alive_in = alive_ff;
      ovf_in   = ovf_ff;
      sum_in = sum_ff;
      dx_in = dx_ff;  dy_in = dy_ff;
      d_in = d_ff;    kv_in = kv_ff;
      fmx_in = fmx_ff; fmy_in = fmy_ff;
      nax_in = nax_ff; nay_in = nay_ff;
      pov_in = pov_ff;
      dtsqh_in = dtsqh_ff;

      use_alu = 1'b0;
      alu_req = '0;
      alu_req.op = ALU_MUL;
      req_ok = 1'b0;
      idx = '0;
      s = '0; c = '0; c2 = '0; u = '0;
      t50 = '0; fx = '0; fy = '0;
      adv_pair = 1'b0;
      ovi = 1'b0; ovj = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (cmd_type'(req_command) == CMD_LOAD) begin
                  req_ok = 32'(req_body_index) < MAX_BODIES;
                  idx = IW'(req_body_index);
                  if (req_ok) begin
                     alive_in[idx] = req_body_alive;
                     mass_in[idx]  = req_body_mass;
                     px_in[idx] = req_start_pos_x;
                     py_in[idx] = req_start_pos_y;
                     vx_in[idx] = req_start_vel_x;
                     vy_in[idx] = req_start_vel_y;
                     ax_in[idx] = '0;
                     ay_in[idx] = '0;
                     fsx_in[idx] = '0;
                     fsy_in[idx] = '0;
                     ld_in = idx;
                     if (req_body_mass == '0) inv_in[idx] = MAX_MAG;
                     else state_in = ST_INV;
                  end
               end else begin
                  state_in = ST_DTSQ;
               end
            end
         end

         ST_INV: begin
            // inverse mass = 2^64 / m
            use_alu = 1'b1;
            alu_req.op  = ALU_DIV;
            alu_req.num = 98'h1 << 64;
            alu_req.den = {1'b0, mass_ff[ld_ff]};
            if (alu_done) begin
               c = div_cap(alu_res[95:0], MAX_MAG);
               inv_in[ld_ff] = c.v;
               state_in = ST_IDLE;
            end
         end

         ST_DTSQ: begin
            use_alu = 1'b1;
            alu_req.a = {32'b0, time_step_ff};
            alu_req.b = {32'b0, time_step_ff};
            if (alu_done) begin
               dtsqh_in = alu_res[64:33];
               state_in = ST_PRED;
               i_in = '0;
               ph_in = '0;
            end
         end

         ST_PRED: begin
            // predict position: pos + vel*dt + acc*dt^2/2
            use_alu = 1'b1;
            unique case (ph_ff)
               4'd0: begin
                  alu_req.a = mag64(sext50(vx_ff[i_ff]));
                  alu_req.b = {32'b0, time_step_ff};
               end
               4'd1: begin
                  alu_req.a = mag64(sext50(ax_ff[i_ff]));
                  alu_req.b = {32'b0, dtsqh_ff};
               end
               4'd2: begin
                  alu_req.a = mag64(sext50(vy_ff[i_ff]));
                  alu_req.b = {32'b0, time_step_ff};
               end
               default: begin
                  alu_req.a = mag64(sext50(ay_ff[i_ff]));
                  alu_req.b = {32'b0, dtsqh_ff};
               end
            endcase
            if (alu_done) begin
               unique case (ph_ff)
                  4'd0: begin
                     s = smul_fin(alu_res, vx_ff[i_ff][47]);
                     ovf_in[i_ff] = (alive_ff[i_ff] && inv_ff[i_ff] == MAX_MAG) | s.ov;
                     sum_in = sext50(px_ff[i_ff]) + sext50(s.v);
                  end
                  4'd1: begin
                     s = smul_fin(alu_res, ax_ff[i_ff][47]);
                     c = clamp50(sum_ff + sext50(s.v));
                     npx_in[i_ff] = c.v;
                     ovf_in[i_ff] = ovf_ff[i_ff] | s.ov | c.ov;
                  end
                  4'd2: begin
                     s = smul_fin(alu_res, vy_ff[i_ff][47]);
                     ovf_in[i_ff] = ovf_ff[i_ff] | s.ov;
                     sum_in = sext50(py_ff[i_ff]) + sext50(s.v);
                  end
                  default: begin
                     s = smul_fin(alu_res, ay_ff[i_ff][47]);
                     c = clamp50(sum_ff + sext50(s.v));
                     npy_in[i_ff] = c.v;
                     ovf_in[i_ff] = ovf_ff[i_ff] | s.ov | c.ov;
                  end
               endcase
               if (ph_ff == 4'd3) begin
                  ph_in = '0;
                  if (i_ff == LAST) begin
                     state_in = ST_PAIR;
                     i_in = '0;
                     j_in = IW'(1);
                  end else begin
                     i_in = i_ff + 1'b1;
                  end
               end else begin
                  ph_in = ph_ff + 1'b1;
               end
            end
         end

         ST_PAIR: begin
            // one pair: distance, sqrt, k = G*mi*mj, two divides, force split
            unique case (ph_ff)
               4'd0: begin
                  if (alive_ff[i_ff] && alive_ff[j_ff]) begin
                     c  = clamp50(sext50(npx_ff[i_ff]) - sext50(npx_ff[j_ff]));
                     c2 = clamp50(sext50(npy_ff[i_ff]) - sext50(npy_ff[j_ff]));
                     dx_in = c.v;
                     dy_in = c2.v;
                     pov_in = c.ov | c2.ov;
                     ph_in = 4'd1;
                  end else begin
                     adv_pair = 1'b1;
                  end
               end
               4'd1: begin
                  use_alu = 1'b1;
                  alu_req.a = mag64(sext50(dx_ff));
                  alu_req.b = mag64(sext50(dx_ff));
                  if (alu_done) ph_in = 4'd2;
               end
               4'd2: begin
                  use_alu = 1'b1;
                  alu_req.op = ALU_MAC;
                  alu_req.a = mag64(sext50(dy_ff));
                  alu_req.b = mag64(sext50(dy_ff));
                  if (alu_done) ph_in = 4'd3;
               end
               4'd3: begin
                  use_alu = 1'b1;
                  alu_req.op  = ALU_SQRT;
                  alu_req.num = alu_res[97:0];
                  if (alu_done) begin
                     d_in = alu_res[48:0];
                     if (alu_res[48:0] == '0) begin
                        ovf_in[i_ff] = 1'b1;
                        ovf_in[j_ff] = 1'b1;
                        adv_pair = 1'b1;
                     end else begin
                        ph_in = 4'd4;
                     end
                  end
               end
               4'd4, 4'd5: begin
                  use_alu = 1'b1;
                  alu_req.a = (ph_ff == 4'd4) ? {16'b0, gravity_ff} : {16'b0, kv_ff};
                  alu_req.b = (ph_ff == 4'd4) ? {16'b0, mass_ff[i_ff]}
                                              : {16'b0, mass_ff[j_ff]};
                  if (alu_done) begin
                     u = umul_fin(alu_res);
                     kv_in = u.v;
                     pov_in = pov_ff | u.ov;
                     ph_in = ph_ff + 1'b1;
                  end
               end
               4'd6, 4'd7: begin
                  use_alu = 1'b1;
                  alu_req.op  = ALU_DIV;
                  alu_req.num = {18'b0, kv_ff, 32'b0};
                  alu_req.den = d_ff;
                  if (alu_done) begin
                     c = div_cap(alu_res[95:0], MAX_MAG);
                     kv_in = c.v;
                     pov_in = pov_ff | c.ov;
                     ph_in = ph_ff + 1'b1;
                  end
               end
               4'd8, 4'd10: begin
                  use_alu = 1'b1;
                  alu_req.a = {16'b0, kv_ff};
                  alu_req.b = (ph_ff == 4'd8) ? mag64(sext50(dx_ff)) : mag64(sext50(dy_ff));
                  if (alu_done) ph_in = ph_ff + 1'b1;
               end
               4'd9, 4'd11: begin
                  use_alu = 1'b1;
                  alu_req.op  = ALU_DIV;
                  alu_req.num = {2'b0, alu_res[95:0]};
                  alu_req.den = d_ff;
                  if (alu_done) begin
                     c = div_cap(alu_res[95:0], MAX_POS);
                     if (ph_ff == 4'd9) fmx_in = c.v;
                     else fmy_in = c.v;
                     pov_in = pov_ff | c.ov;
                     ph_in = ph_ff + 1'b1;
                  end
               end
               4'd12: begin
                  // force points against the separation
                  fx = (!dx_ff[47] && dx_ff != '0) ? -sext50(fmx_ff) : sext50(fmx_ff);
                  fy = (!dy_ff[47] && dy_ff != '0) ? -sext50(fmy_ff) : sext50(fmy_ff);
                  ovi = ovf_ff[i_ff] | pov_ff;
                  ovj = ovf_ff[j_ff] | pov_ff;
                  c = clamp50(sext50(fsx_ff[i_ff]) + fx);
                  fsx_in[i_ff] = c.v;
                  ovi = ovi | c.ov;
                  c = clamp50(sext50(fsy_ff[i_ff]) + fy);
                  fsy_in[i_ff] = c.v;
                  ovi = ovi | c.ov;
                  c = clamp50(sext50(fsx_ff[j_ff]) - fx);
                  fsx_in[j_ff] = c.v;
                  ovj = ovj | c.ov;
                  c = clamp50(sext50(fsy_ff[j_ff]) - fy);
                  fsy_in[j_ff] = c.v;
                  ovj = ovj | c.ov;
                  ovf_in[i_ff] = ovi;
                  ovf_in[j_ff] = ovj;
                  adv_pair = 1'b1;
               end
               default: begin
                  adv_pair = 1'b1;
               end
            endcase
            // advance to the next pair i < j
            if (adv_pair) begin
               ph_in = '0;
               if (j_ff == LAST) begin
                  if (i_ff == LAST - 1'b1) begin
                     state_in = ST_FIN;
                     i_in = '0;
                  end else begin
                     i_in = i_ff + 1'b1;
                     j_in = i_ff + IW'(2);
                  end
               end else begin
                  j_in = j_ff + 1'b1;
               end
            end
         end

         ST_FIN: begin
            // new acceleration, half-step velocity update, commit
            use_alu = 1'b1;
            unique case (ph_ff)
               4'd0: begin
                  alu_req.a = mag64(sext50(fsx_ff[i_ff]));
                  alu_req.b = {16'b0, inv_ff[i_ff]};
               end
               4'd1: begin
                  alu_req.a = mag64(sext50(fsy_ff[i_ff]));
                  alu_req.b = {16'b0, inv_ff[i_ff]};
               end
               4'd2: begin
                  alu_req.a = mag64(sext50(ax_ff[i_ff]) + sext50(nax_ff));
                  alu_req.b = {33'b0, time_step_ff[31:1]};
               end
               default: begin
                  alu_req.a = mag64(sext50(ay_ff[i_ff]) + sext50(nay_ff));
                  alu_req.b = {33'b0, time_step_ff[31:1]};
               end
            endcase
            if (alu_done) begin
               unique case (ph_ff)
                  4'd0: begin
                     s = smul_fin(alu_res, fsx_ff[i_ff][47]);
                     nax_in = s.v;
                     ovf_in[i_ff] = ovf_ff[i_ff] | s.ov;
                  end
                  4'd1: begin
                     s = smul_fin(alu_res, fsy_ff[i_ff][47]);
                     nay_in = s.v;
                     ovf_in[i_ff] = ovf_ff[i_ff] | s.ov;
                  end
                  4'd2: begin
                     t50 = sext50(ax_ff[i_ff]) + sext50(nax_ff);
                     s = smul_fin(alu_res, t50[49]);
                     c = clamp50(sext50(vx_ff[i_ff]) + sext50(s.v));
                     vx_in[i_ff] = c.v;
                     ovf_in[i_ff] = ovf_ff[i_ff] | s.ov | c.ov;
                  end
                  default: begin
                     t50 = sext50(ay_ff[i_ff]) + sext50(nay_ff);
                     s = smul_fin(alu_res, t50[49]);
                     c = clamp50(sext50(vy_ff[i_ff]) + sext50(s.v));
                     vy_in[i_ff] = c.v;
                     ovf_in[i_ff] = ovf_ff[i_ff] | s.ov | c.ov;
                     ax_in[i_ff] = nax_ff;
                     ay_in[i_ff] = nay_ff;
                     px_in[i_ff] = npx_ff[i_ff];
                     py_in[i_ff] = npy_ff[i_ff];
                     fsx_in[i_ff] = '0;
                     fsy_in[i_ff] = '0;
                  end
               endcase
               if (ph_ff == 4'd3) begin
                  ph_in = '0;
                  i_in = (i_ff == LAST) ? '0 : i_ff + 1'b1;
                  if (i_ff == LAST) state_in = ST_OUT;
               end else begin
                  ph_in = ph_ff + 1'b1;
               end
            end
         end

         ST_OUT: begin
            // hand out one report word per slot
            if (!rsp_stall) begin
               if (i_ff == LAST) begin
                  i_in = '0;
                  state_in = ST_IDLE;
               end else begin
                  i_in = i_ff + 1'b1;
               end
            end
         end

         default: state_in = ST_IDLE;
      endcase

      alu_req.start = use_alu && !issued_ff;
      if (alu_req.start) issued_in = 1'b1;
      if (alu_done) issued_in = 1'b0;
   end

   // Hold state; reset clears the body store
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         ph_ff     <= '0;
         i_ff      <= '0;
         j_ff      <= '0;
         ld_ff     <= '0;
         issued_ff <= 1'b0;
         alive_ff  <= '0;
         ovf_ff    <= '0;
         for (int k = 0; k < MAX_BODIES; k++) begin
            px_ff[k] <= '0;  py_ff[k] <= '0;
            vx_ff[k] <= '0;  vy_ff[k] <= '0;
            ax_ff[k] <= '0;  ay_ff[k] <= '0;
            mass_ff[k] <= '0;
            inv_ff[k]  <= '0;
            fsx_ff[k]  <= '0;
            fsy_ff[k]  <= '0;
         end
      end else begin
         state_ff  <= state_in;
         ph_ff     <= ph_in;
         i_ff      <= i_in;
         j_ff      <= j_in;
         ld_ff     <= ld_in;
         issued_ff <= issued_in;
         alive_ff  <= alive_in;
         ovf_ff    <= ovf_in;
         px_ff <= px_in;  py_ff <= py_in;
         vx_ff <= vx_in;  vy_ff <= vy_in;
         ax_ff <= ax_in;  ay_ff <= ay_in;
         mass_ff <= mass_in;
         inv_ff  <= inv_in;
         fsx_ff  <= fsx_in;
         fsy_ff  <= fsy_in;
      end
      npx_ff   <= npx_in;
      npy_ff   <= npy_in;
      sum_ff   <= sum_in;
      dx_ff    <= dx_in;
      dy_ff    <= dy_in;
      d_ff     <= d_in;
      kv_ff    <= kv_in;
      fmx_ff   <= fmx_in;
      fmy_ff   <= fmy_in;
      nax_ff   <= nax_in;
      nay_ff   <= nay_in;
      pov_ff   <= pov_in;
      dtsqh_ff <= dtsqh_in;
   end

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         time_step_ff <= TIME_STEP_RESET;
         gravity_ff   <= GRAVITY_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_type'(csr_index))
            CSR_TIME_STEP: time_step_ff <= csr_write_data[31:0];
            CSR_GRAVITY:   gravity_ff   <= csr_write_data;
         endcase
      end
   end

   // Report word
   assign req_stall     = state_ff != ST_IDLE;
   assign rsp_valid     = state_ff == ST_OUT;
   assign rsp_out_index = 3'(i_ff);
   assign rsp_out_alive = alive_ff[i_ff];
   assign rsp_out_pos_x = px_ff[i_ff];
   assign rsp_out_pos_y = py_ff[i_ff];
   assign rsp_out_vel_x = vx_ff[i_ff];
   assign rsp_out_vel_y = vy_ff[i_ff];
   assign rsp_out_acc_x = ax_ff[i_ff];
   assign rsp_out_acc_y = ay_ff[i_ff];
   assign rsp_overflow  = ovf_ff[i_ff];
   assign rsp_last      = i_ff == LAST;

   `ASSERT_IMPLY(a_no_req_while_rsp, clock, reset, rsp_valid, req_stall)
   `ASSERT_IMPLY(a_done_after_issue, clock, reset, alu_done, issued_ff)
   `ASSERT_NEXT(a_last_ends_tick, clock, reset, rsp_valid && !rsp_stall && rsp_last, state_ff == ST_IDLE)

endmodule
